### hdl/bounding_sphere_merge_assert.svh
// ---------------------------------------------------------------------------
// Bounding sphere merge assertion macros
// Concurrent assertion wrappers, compiled out when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef BOUNDING_SPHERE_MERGE_ASSERT_SVH
`define BOUNDING_SPHERE_MERGE_ASSERT_SVH
`ifndef SYNTH
`define BSM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bounding_sphere_merge assertion failed");
`define BSM_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("bounding_sphere_merge assertion failed");
`else
`define BSM_ASSERT(lbl, clk, rst_n, prop)
`define BSM_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

### hdl/bsm_pkg.sv
// ---------------------------------------------------------------------------
// Bounding sphere merge package
// Pipeline context, cell payload types and sizing constants.
// ---------------------------------------------------------------------------
`default_nettype none
package bsm_pkg;

  localparam int SQ_N = 33;
  localparam int DV_N = 33;
  localparam logic [30:0] RAD_MAX = 31'h7FFF_FFFF;

  typedef struct packed {
    logic [2:0][31:0] ac;
    logic [2:0][31:0] csel;
    logic [2:0]       neg;
    logic [2:0][32:0] adl;
    logic [29:0]      ra;
    logic [29:0]      rmax;
    logic [30:0]      sum;
    logic [29:0]      diff;
    logic [2:0][65:0] sq;
    logic [59:0]      dfsq;
    logic [61:0]      smsq;
    logic [65:0]      dsq;
    logic             contain;
    logic             overlap;
    logic [32:0]      d;
    logic [32:0]      step;
    logic [30:0]      rsat;
    logic [61:0]      rsq;
    logic [59:0]      rasq;
    logic [2:0][49:0] plo;
    logic [2:0][48:0] phi;
    logic [61:0]      grow;
    logic [2:0][65:0] nn;
  } bsm_ctx_t;

  typedef struct packed {
    logic [35:0] rem;
    logic [65:0] rad;
    logic [32:0] root;
  } bsm_sq_t;

  typedef struct packed {
    logic [2:0][32:0] rem;
    logic [2:0][32:0] num;
    logic [2:0][32:0] quo;
  } bsm_dv_t;

endpackage
`default_nettype wire

### hdl/bsm_sqrt_cell.sv
// ---------------------------------------------------------------------------
// Square root cell
// Resolves one root bit per cycle while adv is high and passes the context to the next cell.
// ---------------------------------------------------------------------------
`default_nettype none
module bsm_sqrt_cell import bsm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     adv,
  input  logic     in_vld,
  input  bsm_ctx_t in_ctx,
  input  bsm_sq_t  in_sq,
  output logic     out_vld,
  output bsm_ctx_t out_ctx,
  output bsm_sq_t  out_sq
);
  logic     vld_r, vld_nxt;
  bsm_ctx_t ctx_r;
  bsm_sq_t  sq_r, sq_nxt;
  logic [35:0] cur, trial;

  always_comb begin
    cur        = {in_sq.rem[33:0], in_sq.rad[65:64]};
    trial      = {1'b0, in_sq.root, 2'b01};
    sq_nxt.rad = {in_sq.rad[63:0], 2'b00};
    if (cur >= trial) begin
      sq_nxt.rem  = cur - trial;
      sq_nxt.root = {in_sq.root[31:0], 1'b1};
    end else begin
      sq_nxt.rem  = cur;
      sq_nxt.root = {in_sq.root[31:0], 1'b0};
    end
    vld_nxt = adv ? in_vld : vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctx_r <= in_ctx;
      sq_r  <= sq_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_ctx = ctx_r;
  assign out_sq  = sq_r;
endmodule
`default_nettype wire

### hdl/bsm_div_cell.sv
// ---------------------------------------------------------------------------
// Divider cell
// One restoring quotient bit per cycle while adv is high, for each of the three axis lanes.
// ---------------------------------------------------------------------------
`default_nettype none
module bsm_div_cell import bsm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     adv,
  input  logic     in_vld,
  input  bsm_ctx_t in_ctx,
  input  bsm_dv_t  in_dv,
  output logic     out_vld,
  output bsm_ctx_t out_ctx,
  output bsm_dv_t  out_dv
);
  logic     vld_r, vld_nxt;
  bsm_ctx_t ctx_r;
  bsm_dv_t  dv_r, dv_nxt;
  logic [2:0][33:0] cur;
  logic [33:0] dvs;

  always_comb begin
    dvs = {1'b0, in_ctx.d};
    for (int k = 0; k < 3; k++) begin
      cur[k]        = {in_dv.rem[k], in_dv.num[k][32]};
      dv_nxt.num[k] = {in_dv.num[k][31:0], 1'b0};
      if (cur[k] >= dvs) begin
        dv_nxt.rem[k] = 33'(cur[k] - dvs);
        dv_nxt.quo[k] = {in_dv.quo[k][31:0], 1'b1};
      end else begin
        dv_nxt.rem[k] = cur[k][32:0];
        dv_nxt.quo[k] = {in_dv.quo[k][31:0], 1'b0};
      end
    end
    vld_nxt = adv ? in_vld : vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctx_r <= in_ctx;
      dv_r  <= dv_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_ctx = ctx_r;
  assign out_dv  = dv_r;
endmodule
`default_nettype wire

### hdl/bounding_sphere_merge.sv
// Stages: s1 to s4, 33 square root cells, m1 to m3, 33 divider cells, output.
// Throughput: one beat per cycle; a stalled output holds the whole pipeline.
// Reset: synchronous active low, clears every stage valid bit; no state else.
// ---------------------------------------------------------------------------
// Bounding sphere merge
// Smallest enclosing sphere of two spheres, overlap flag and radius growth.
// ---------------------------------------------------------------------------
`default_nettype none
`include "bounding_sphere_merge_assert.svh"
module bounding_sphere_merge import bsm_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // a_x, a_y, a_z, a_radius, b_x, b_y, b_z, b_radius, zero pad
  input  logic [255:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // merged_x, merged_y, merged_z, merged_radius, overlap, growth, zero pad
  output logic [191:0] out_tdata
);
  logic adv;

  logic     v1_r, v2_r, v3_r, v4_r, vm1_r, vm2_r, vm3_r, vo_r;
  bsm_ctx_t s1_r, s1_nxt, s2_r, s2_nxt, s3_r, s3_nxt, s4_r, s4_nxt;
  bsm_ctx_t m1_r, m1_nxt, m2_r, m2_nxt, m3_r, m3_nxt;

  logic     sq_vld [0:SQ_N];
  bsm_ctx_t sq_ctx [0:SQ_N];
  bsm_sq_t  sq_dat [0:SQ_N];
  logic     dv_vld [0:DV_N];
  bsm_ctx_t dv_ctx [0:DV_N];
  bsm_dv_t  dv_dat [0:DV_N];

  logic [2:0][31:0] mc_r, mc_nxt;
  logic [30:0] rad_r;
  logic        ovl_r, cont_r;
  logic [61:0] grow_r;
  logic [29:0] rmax_r;

  assign adv       = !(vo_r && !out_tready);
  assign in_tready = adv;

  // input decode and deltas
  always_comb begin
    logic [31:0] a, b;
    logic [32:0] dl;
    logic [29:0] ra, rb;
    s1_nxt = '0;
    ra     = in_tdata[125:96];
    rb     = in_tdata[251:222];
    for (int k = 0; k < 3; k++) begin
      a = in_tdata[32*k +: 32];
      b = in_tdata[126 + 32*k +: 32];
      dl = {b[31], b} - {a[31], a};
      s1_nxt.ac[k]   = a;
      s1_nxt.csel[k] = (ra > rb) ? a : b;
      s1_nxt.neg[k]  = dl[32];
      s1_nxt.adl[k]  = dl[32] ? 33'(-dl) : dl;
    end
    s1_nxt.ra   = ra;
    s1_nxt.rmax = (ra > rb) ? ra : rb;
    s1_nxt.diff = (ra > rb) ? ra - rb : rb - ra;
    s1_nxt.sum  = {1'b0, ra} + {1'b0, rb};
  end

  always_comb begin
    s2_nxt = s1_r;
    for (int k = 0; k < 3; k++) begin
      s2_nxt.sq[k] = 66'(s1_r.adl[k]) * 66'(s1_r.adl[k]);
    end
    s2_nxt.dfsq = 60'(s1_r.diff) * 60'(s1_r.diff);
    s2_nxt.smsq = 62'(s1_r.sum) * 62'(s1_r.sum);
  end

  always_comb begin
    s3_nxt     = s2_r;
    s3_nxt.dsq = s2_r.sq[0] + s2_r.sq[1] + s2_r.sq[2];
  end

  always_comb begin
    s4_nxt         = s3_r;
    s4_nxt.contain = s3_r.dsq <= {6'b0, s3_r.dfsq};
    s4_nxt.overlap = s3_r.dsq < {4'b0, s3_r.smsq};
  end

  assign sq_vld[0]      = v4_r;
  assign sq_ctx[0]      = s4_r;
  assign sq_dat[0].rem  = '0;
  assign sq_dat[0].rad  = s4_r.dsq;
  assign sq_dat[0].root = '0;

  for (genvar i = 0; i < SQ_N; i++) begin : g_sq
    bsm_sqrt_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .in_vld  (sq_vld[i]),
      .in_ctx  (sq_ctx[i]),
      .in_sq   (sq_dat[i]),
      .out_vld (sq_vld[i+1]),
      .out_ctx (sq_ctx[i+1]),
      .out_sq  (sq_dat[i+1])
    );
  end

  // merged radius, centre step, saturated radius
  always_comb begin
    logic [33:0] sumd;
    logic [32:0] radm, rad;
    m1_nxt   = sq_ctx[SQ_N];
    m1_nxt.d = sq_dat[SQ_N].root;
    sumd     = {1'b0, sq_dat[SQ_N].root} + {3'b0, sq_ctx[SQ_N].sum};
    radm     = sumd[33:1];
    m1_nxt.step = (radm > {3'b0, sq_ctx[SQ_N].ra}) ? radm - {3'b0, sq_ctx[SQ_N].ra} : '0;
    rad = sq_ctx[SQ_N].contain ? {3'b0, sq_ctx[SQ_N].rmax} : radm;
    m1_nxt.rsat = (rad[32:31] != 2'b00) ? RAD_MAX : rad[30:0];
  end

  always_comb begin
    m2_nxt = m1_r;
    for (int k = 0; k < 3; k++) begin
      m2_nxt.plo[k] = 50'(m1_r.adl[k]) * 50'(m1_r.step[16:0]);
      m2_nxt.phi[k] = 49'(m1_r.adl[k]) * 49'(m1_r.step[32:17]);
    end
    m2_nxt.rsq  = 62'(m1_r.rsat) * 62'(m1_r.rsat);
    m2_nxt.rasq = 60'(m1_r.ra) * 60'(m1_r.ra);
  end

  always_comb begin
    m3_nxt = m2_r;
    for (int k = 0; k < 3; k++) begin
      m3_nxt.nn[k] = 66'(m2_r.plo[k]) + {m2_r.phi[k], 17'b0};
    end
    m3_nxt.grow = m2_r.rsq - {2'b0, m2_r.rasq};
  end

  assign dv_vld[0] = vm3_r;
  assign dv_ctx[0] = m3_r;
  always_comb begin
    dv_dat[0] = '0;
    for (int k = 0; k < 3; k++) begin
      dv_dat[0].rem[k] = m3_r.nn[k][65:33];
      dv_dat[0].num[k] = m3_r.nn[k][32:0];
    end
  end

  for (genvar i = 0; i < DV_N; i++) begin : g_dv
    bsm_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .in_vld  (dv_vld[i]),
      .in_ctx  (dv_ctx[i]),
      .in_dv   (dv_dat[i]),
      .out_vld (dv_vld[i+1]),
      .out_ctx (dv_ctx[i+1]),
      .out_dv  (dv_dat[i+1])
    );
  end

  // centre offset with saturation, or the selected centre on containment
  always_comb begin
    logic [34:0] acx, offx, sm;
    for (int k = 0; k < 3; k++) begin
      acx  = {{3{dv_ctx[DV_N].ac[k][31]}}, dv_ctx[DV_N].ac[k]};
      offx = {2'b0, dv_dat[DV_N].quo[k]};
      sm   = dv_ctx[DV_N].neg[k] ? acx - offx : acx + offx;
      if (dv_ctx[DV_N].contain) begin
        mc_nxt[k] = dv_ctx[DV_N].csel[k];
      end else if (sm[34:31] == 4'b0000 || sm[34:31] == 4'b1111) begin
        mc_nxt[k] = sm[31:0];
      end else begin
        mc_nxt[k] = sm[34] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      v4_r  <= 1'b0;
      vm1_r <= 1'b0;
      vm2_r <= 1'b0;
      vm3_r <= 1'b0;
      vo_r  <= 1'b0;
    end else if (adv) begin
      v1_r  <= in_tvalid;
      v2_r  <= v1_r;
      v3_r  <= v2_r;
      v4_r  <= v3_r;
      vm1_r <= sq_vld[SQ_N];
      vm2_r <= vm1_r;
      vm3_r <= vm2_r;
      vo_r  <= dv_vld[DV_N];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r   <= s1_nxt;
      s2_r   <= s2_nxt;
      s3_r   <= s3_nxt;
      s4_r   <= s4_nxt;
      m1_r   <= m1_nxt;
      m2_r   <= m2_nxt;
      m3_r   <= m3_nxt;
      mc_r   <= mc_nxt;
      rad_r  <= dv_ctx[DV_N].rsat;
      ovl_r  <= dv_ctx[DV_N].overlap;
      cont_r <= dv_ctx[DV_N].contain;
      grow_r <= dv_ctx[DV_N].grow;
      rmax_r <= dv_ctx[DV_N].rmax;
    end
  end

  assign out_tvalid = vo_r;
  assign out_tdata  = {2'b00, grow_r, ovl_r, rad_r, mc_r[2], mc_r[1], mc_r[0]};

  `BSM_ASSERT(a_rad_cover, clk, rst_n, vo_r |-> rad_r >= {1'b0, rmax_r})
  `BSM_ASSERT(a_rad_contain, clk, rst_n, (vo_r && cont_r) |-> rad_r == {1'b0, rmax_r})
  `BSM_ASSERT(a_off_bound, clk, rst_n, (dv_vld[DV_N] && !dv_ctx[DV_N].contain) |-> (dv_dat[DV_N].quo[0] <= dv_ctx[DV_N].adl[0] && dv_dat[DV_N].quo[1] <= dv_ctx[DV_N].adl[1] && dv_dat[DV_N].quo[2] <= dv_ctx[DV_N].adl[2]))
endmodule
`default_nettype wire

### bench/testbench.sv
// ---------------------------------------------------------------------------
// Bounding sphere merge testbench
// Streams sphere pairs through the block with random gaps and output stalls,
// predicts each merged sphere, overlap flag and growth, and compares per beat.
// ---------------------------------------------------------------------------
`default_nettype none
module testbench;

  localparam int    LATENCY   = 74;
  localparam int    N_RANDOM  = 1850;
  localparam longint CYC_LIMIT = 400000;
  localparam logic [30:0] RADIUS_CAP = 31'h7FFF_FFFF;

  typedef struct packed {
    logic [29:0] b_r;
    logic [31:0] b_z, b_y, b_x;
    logic [29:0] a_r;
    logic [31:0] a_z, a_y, a_x;
  } pair_t;

  typedef struct packed {
    logic [61:0] growth;
    logic        overlap;
    logic [30:0] radius;
    logic [31:0] mz, my, mx;
  } merged_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_valid = 1'b0;
  logic         in_ready;
  logic [255:0] in_data = '0;
  logic         out_valid;
  logic         out_ready = 1'b0;
  logic [191:0] out_data;

  pair_t   pending_pairs[$];
  merged_t merges_due[$];
  int      n_fail = 0;
  int      n_checked = 0;
  int      n_overlap = 0;
  int      in_gap = 0;
  int      out_gap = 0;
  int      hold_off = 0;
  bit      in_took = 1'b0;
  longint  cyc = 0;

  always #4 clk = ~clk;

  bounding_sphere_merge i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_valid),
    .in_tready (in_ready),
    .in_tdata  (in_data),
    .out_tvalid(out_valid),
    .out_tready(out_ready),
    .out_tdata (out_data)
  );

  function automatic logic [32:0] isqrt(logic [65:0] n);
    logic [32:0]  r;
    logic [32:0]  c;
    logic [127:0] p;
    r = '0;
    for (int b = 32; b >= 0; b--) begin
      c = r | (33'd1 << b);
      p = 128'(c) * 128'(c);
      if (p <= 128'(n)) r = c;
    end
    return r;
  endfunction

  function automatic logic signed [63:0] clamp32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic merged_t merge_spheres(pair_t p);
    merged_t m;
    logic signed [63:0] ac[3], bc[3], dl[3], mc[3];
    logic [63:0]  ad[3];
    logic [127:0] dsq, lim, num;
    logic [63:0]  ra, rb, diff, sum, rad, step, d, off, rs;
    ac[0] = 64'(signed'(p.a_x)); ac[1] = 64'(signed'(p.a_y)); ac[2] = 64'(signed'(p.a_z));
    bc[0] = 64'(signed'(p.b_x)); bc[1] = 64'(signed'(p.b_y)); bc[2] = 64'(signed'(p.b_z));
    ra = 64'(p.a_r);
    rb = 64'(p.b_r);
    dsq = '0;
    for (int k = 0; k < 3; k++) begin
      dl[k] = bc[k] - ac[k];
      ad[k] = dl[k] < 0 ? 64'(-dl[k]) : 64'(dl[k]);
      dsq += 128'(ad[k]) * 128'(ad[k]);
    end
    diff = ra > rb ? ra - rb : rb - ra;
    sum = ra + rb;
    lim = 128'(diff) * 128'(diff);
    if (dsq <= lim) begin
      for (int k = 0; k < 3; k++) mc[k] = ra > rb ? ac[k] : bc[k];
      rad = ra > rb ? ra : rb;
    end else begin
      d = 64'(isqrt(dsq[65:0]));
      rad = (d + sum) >> 1;
      step = rad > ra ? rad - ra : 0;
      for (int k = 0; k < 3; k++) begin
        num = 128'(ad[k]) * 128'(step);
        off = 64'(num / 128'(d));
        if (off > 64'h2_0000_0000) off = 64'h2_0000_0000;
        mc[k] = clamp32(dl[k] < 0 ? ac[k] - signed'(off) : ac[k] + signed'(off));
      end
    end
    rs = rad > 64'(RADIUS_CAP) ? 64'(RADIUS_CAP) : rad;
    m.mx = mc[0][31:0];
    m.my = mc[1][31:0];
    m.mz = mc[2][31:0];
    m.radius = rs[30:0];
    m.overlap = dsq < 128'(sum) * 128'(sum);
    m.growth = 62'(rs * rs - ra * ra);
    return m;
  endfunction

  function automatic logic [31:0] rnd_coord(int mode);
    case (mode)
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      default: return 32'($signed($urandom_range(0, 400)) - 200) <<< 16;
    endcase
  endfunction

  function automatic logic [29:0] rnd_radius();
    case ($urandom_range(0, 3))
      0: return 30'($urandom);
      1: return 30'($urandom_range(0, 200)) << 16;
      2: return 30'($urandom_range(0, 3000000));
      default: return $urandom_range(0, 1) ? 30'h3FFF_FFFF : 30'd0;
    endcase
  endfunction

  function automatic pair_t rnd_pair();
    pair_t p;
    int mode;
    mode = $urandom_range(0, 2);
    p.a_x = rnd_coord(mode); p.a_y = rnd_coord(mode); p.a_z = rnd_coord(mode);
    p.a_r = rnd_radius();
    if ($urandom_range(0, 4) == 0) begin
      // concentric or near-concentric pair
      p.b_x = p.a_x + 32'($urandom_range(0, 3));
      p.b_y = p.a_y; p.b_z = p.a_z;
    end else begin
      p.b_x = rnd_coord(mode); p.b_y = rnd_coord(mode); p.b_z = rnd_coord(mode);
    end
    p.b_r = $urandom_range(0, 5) == 0 ? p.a_r : rnd_radius();
    return p;
  endfunction

  function automatic pair_t mk_pair(logic [31:0] ax, ay, az, logic [29:0] ar,
                                    logic [31:0] bx, by, bz, logic [29:0] br);
    pair_t p;
    p.a_x = ax; p.a_y = ay; p.a_z = az; p.a_r = ar;
    p.b_x = bx; p.b_y = by; p.b_z = bz; p.b_r = br;
    return p;
  endfunction

  function automatic int rnd_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic queue_pair(pair_t p);
    pending_pairs = {pending_pairs, p};
  endtask

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_took) begin
        if (in_gap > 0 || pending_pairs.size() == 0) begin
          if (in_gap > 0) in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else begin
          in_data <= {4'd0, pending_pairs.pop_front()};
          in_valid <= 1'b1;
          in_gap <= rnd_gap();
        end
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_ready <= 1'b0;
      end else if (cyc > 3000 && cyc < 3010) begin
        hold_off <= 400;
        out_ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        out_gap <= rnd_gap();
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    merged_t got, want;
    cyc <= cyc + 1;
    in_took <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      merges_due = {merges_due, merge_spheres(pair_t'(in_data[251:0]))};
    end
    if (rst_n && out_valid && out_ready) begin
      got = merged_t'(out_data[189:0]);
      if (merges_due.size() == 0) begin
        $error("output beat with nothing expected");
        n_fail++;
      end else begin
        want = merges_due.pop_front();
        n_checked++;
        if (got.overlap) n_overlap++;
        if (got.mx != want.mx) begin
          $error("merged_x expected %h got %h", want.mx, got.mx); n_fail++;
        end
        if (got.my != want.my) begin
          $error("merged_y expected %h got %h", want.my, got.my); n_fail++;
        end
        if (got.mz != want.mz) begin
          $error("merged_z expected %h got %h", want.mz, got.mz); n_fail++;
        end
        if (got.radius != want.radius) begin
          $error("merged_radius expected %h got %h", want.radius, got.radius); n_fail++;
        end
        if (got.overlap != want.overlap) begin
          $error("overlap expected %b got %b", want.overlap, got.overlap); n_fail++;
        end
        if (got.growth != want.growth) begin
          $error("growth expected %h got %h", want.growth, got.growth); n_fail++;
        end
      end
    end
    if (cyc > CYC_LIMIT) begin
      $display("timeout at cycle %0d", cyc);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    // extremes, containment ties, concentric centres, saturation
    queue_pair(mk_pair(0, 0, 0, 0, 0, 0, 0, 0));
    queue_pair(mk_pair(0, 0, 0, 30'h10000, 0, 0, 0, 30'h10000));
    queue_pair(mk_pair(0, 0, 0, 30'h20000, 0, 0, 0, 30'h10000));
    queue_pair(mk_pair(5, 6, 7, 30'h10000, 5, 6, 7, 30'h30000));
    queue_pair(mk_pair(0, 0, 0, 30'h10000, 32'h30000, 0, 0, 30'h20000));
    queue_pair(mk_pair(0, 0, 0, 30'h10000, 32'h20000, 0, 0, 30'h10000));
    queue_pair(mk_pair(0, 0, 0, 30'h10000, 32'h10000, 0, 0, 30'h10000));
    queue_pair(mk_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0,
                       32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
    queue_pair(mk_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                       30'h3FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                       32'h8000_0000, 30'h3FFF_FFFF));
    queue_pair(mk_pair(32'h8000_0000, 0, 32'h7FFF_FFFF, 30'h3FFF_FFFF,
                       32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 0));
    queue_pair(mk_pair(32'h7FFF_FFFF, 0, 0, 30'h3FFF_FFFF,
                       32'h7FFF_FFFF, 0, 0, 30'h3FFF_FFFF));
    queue_pair(mk_pair(0, 0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1));
    queue_pair(mk_pair(0, 0, 0, 30'h3FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0));
    queue_pair(mk_pair(32'h7FFF_0000, 0, 0, 30'h3FFF_FFFF,
                       32'h8000_0000, 0, 0, 30'h3FFF_FFFF));
    for (int i = 0; i < N_RANDOM; i++) queue_pair(rnd_pair());
    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    wait (pending_pairs.size() == 0 && !in_valid);
    wait (merges_due.size() == 0);
    repeat (LATENCY + 20) @(posedge clk);
    $display("%0d sphere pairs checked, %0d overlapping; with long output stall",
             n_checked, n_overlap);
    if (n_fail == 0 && merges_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire
